FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the serial line assembler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define SLA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SLA_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/sla_pkg.sv
// Types, constants and helpers for the serial line assembler.
package sla_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int BUF_LAST  = BUF_DEPTH - 1;
    localparam int MAXL_W    = 6;
    localparam int BYTE_W    = 8;

    localparam logic [MAXL_W-1:0] MAX_LINE_RST = 6'd63;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_BINLEN = 2'd1,
        MODE_BINPAY = 2'd2
    } mode_t;

    typedef enum logic {
        ST_COLLECT = 1'b0,
        ST_EMIT    = 1'b1
    } state_t;

    // Line limit clamped to the buffer.
    function automatic logic [ADDR_W-1:0] eff_max(input logic [MAXL_W-1:0] v);
        if ({3'b000, v} > 9'(BUF_LAST))
            return ADDR_W'(BUF_LAST);
        else
            return ADDR_W'(v);
    endfunction

endpackage

FILE: rtl/core/sla_line_ram.sv
// Line buffer RAM: one write port, one registered read port.
module sla_line_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/serial_line_assembler_top.sv
// Serial line assembler: collects received bytes into lines and streams them out.
//
// Usage:
//   s_valid/s_ready/s_rx_byte carries received bytes, one per transaction.
//   m_valid/m_ready carries the finished line, one byte per transaction, with
//   m_byte_index, m_is_binary and m_last (set on the final byte).
//   cfg_valid/cfg_ready/cfg_data writes max_line; write it only while idle.
// Throughput: while collecting, one byte per cycle. The byte that ends a line
//   switches the block to readout: the line store has one read port, so a line
//   of N bytes holds s_ready low until all N bytes have been read from it.
// Readout: the first byte of a line passes through the read stage and the output
//   register to m_valid; the rest follow one per cycle while m_ready is high.
// Stalls: reads stop while the read stage and output register are both full,
//   so a stalled receiver loses nothing; the next line waits for readout.
// Reset: collection restarts in text mode at line start with max_line = 63.
//   The line store is not cleared; only entries written in the current line
//   are ever read.
`include "assert_macros.svh"

module serial_line_assembler_top
    import sla_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_line_byte,
    output logic [ADDR_W-1:0] m_byte_index,
    output logic              m_is_binary,
    output logic              m_last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MAXL_W-1:0] cfg_data
);

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] rem_reg, rem_next;
    logic [MAXL_W-1:0] max_line_reg, max_line_next;
    logic [ADDR_W-1:0] last_idx_reg, last_idx_next;
    logic              bin_reg, bin_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;

    logic              p1_valid_reg, p1_valid_next;
    logic [ADDR_W-1:0] p1_idx_reg;
    logic              p1_last_reg;
    logic              p1_bin_reg;

    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_byte_reg;
    logic [ADDR_W-1:0] m_idx_reg;
    logic              m_bin_reg;
    logic              m_last_reg;

    logic              in_acc, cfg_acc;
    logic              issue, out_load, rd_is_last;
    logic              line_end;
    logic [ADDR_W-1:0] end_last;
    logic              end_bin;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] rdata;

    logic [ADDR_W-1:0] budget;
    logic [BYTE_W:0]   need;
    logic [ADDR_W:0]   pos_inc;
    logic [ADDR_W-1:0] rem_dec;

    sla_line_ram #(
        .DEPTH  (BUF_DEPTH),
        .WIDTH  (BYTE_W),
        .ADDR_W (ADDR_W)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (issue),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    assign in_acc     = s_valid && s_ready;
    assign cfg_acc    = cfg_valid && cfg_ready;
    assign out_load   = p1_valid_reg && (!m_valid_reg || m_ready);
    assign rd_is_last = (rd_addr_reg == last_idx_reg);

    // FSM next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT: begin
                if (in_acc && line_end) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (issue && rd_is_last) state_next = ST_COLLECT;
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_ready = 1'b0;
        issue   = 1'b0;
        case (state_reg)
            ST_COLLECT: s_ready = 1'b1;
            ST_EMIT:    issue   = !p1_valid_reg || out_load;
            default: begin
                s_ready = 1'b0;
                issue   = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    // Line collection: decode the incoming byte against the current mode
    always_comb begin
        we        = 1'b0;
        waddr     = pos_reg;
        wdata     = s_rx_byte;
        pos_next  = pos_reg;
        rem_next  = rem_reg;
        mode_next = mode_reg;
        line_end  = 1'b0;
        end_last  = pos_reg;
        end_bin   = 1'b0;

        budget  = (rem_reg >= ADDR_W'(2)) ? rem_reg - ADDR_W'(2) : '0;
        need    = {1'b0, s_rx_byte} + (BYTE_W+1)'(1);
        pos_inc = {1'b0, pos_reg} + (ADDR_W+1)'(1);
        rem_dec = (rem_reg != '0) ? rem_reg - ADDR_W'(1) : rem_reg;

        case (mode_reg)
            MODE_BINLEN: begin
                we        = 1'b1;
                waddr     = ADDR_W'(1);
                pos_next  = ADDR_W'(2);
                mode_next = MODE_BINPAY;
                if (need < (BYTE_W+1)'(budget))
                    rem_next = ADDR_W'(need);
                else
                    rem_next = budget;
                if (rem_next == '0) begin
                    line_end = 1'b1;
                    end_last = ADDR_W'(1);
                    end_bin  = 1'b1;
                end
            end
            MODE_BINPAY: begin
                we       = 1'b1;
                pos_next = pos_inc[ADDR_W-1:0];
                rem_next = rem_dec;
                if (rem_dec == '0 || pos_inc >= (ADDR_W+1)'(BUF_LAST)) begin
                    line_end = 1'b1;
                    end_last = pos_reg;
                    end_bin  = 1'b1;
                end
            end
            default: begin
                if (pos_reg == '0 && s_rx_byte == CH_NUL) begin
                    we        = 1'b1;
                    wdata     = CH_NUL;
                    pos_next  = ADDR_W'(1);
                    mode_next = MODE_BINLEN;
                end else if (pos_reg == '0 && s_rx_byte < CH_SPACE) begin
                    we = 1'b0;      // control byte at line start: dropped
                end else if (s_rx_byte == CH_LF || s_rx_byte == CH_CR) begin
                    we       = 1'b1;
                    wdata    = CH_NUL;
                    line_end = 1'b1;
                end else begin
                    we = 1'b1;
                    // full line keeps overwriting the final slot
                    if (rem_reg != '0) begin
                        pos_next = pos_reg + ADDR_W'(1);
                        rem_next = rem_dec;
                    end
                end
            end
        endcase

        if (line_end) begin
            pos_next  = '0;
            rem_next  = eff_max(max_line_reg);
            mode_next = MODE_TEXT;
        end
        if (!in_acc) begin
            we        = 1'b0;
            pos_next  = pos_reg;
            rem_next  = rem_reg;
            mode_next = mode_reg;
        end
    end

    // Register writes and the readout pipeline
    always_comb begin
        max_line_next = max_line_reg;
        last_idx_next = last_idx_reg;
        bin_next      = bin_reg;
        rd_addr_next  = rd_addr_reg;
        p1_valid_next = p1_valid_reg;
        m_valid_next  = m_valid_reg;

        if (cfg_acc) max_line_next = cfg_data;

        if (in_acc && line_end) begin
            last_idx_next = end_last;
            bin_next      = end_bin;
            rd_addr_next  = '0;
        end else if (issue && !rd_is_last) begin
            rd_addr_next = rd_addr_reg + ADDR_W'(1);
        end

        if (issue)
            p1_valid_next = 1'b1;
        else if (out_load)
            p1_valid_next = 1'b0;

        if (out_load)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_COLLECT;
            mode_reg     <= MODE_TEXT;
            pos_reg      <= '0;
            rem_reg      <= eff_max(MAX_LINE_RST);
            max_line_reg <= MAX_LINE_RST;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            max_line_reg <= max_line_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
            // a new limit applies at once only at text line start
            if (!in_acc && cfg_acc && mode_reg == MODE_TEXT && pos_reg == '0)
                rem_reg <= eff_max(cfg_data);
            else
                rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_idx_reg <= last_idx_next;
        bin_reg      <= bin_next;
        rd_addr_reg  <= rd_addr_next;
        if (issue) begin
            p1_idx_reg  <= rd_addr_reg;
            p1_last_reg <= rd_is_last;
            p1_bin_reg  <= bin_reg;
        end
        if (out_load) begin
            m_byte_reg <= rdata;
            m_idx_reg  <= p1_idx_reg;
            m_bin_reg  <= p1_bin_reg;
            m_last_reg <= p1_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_line_byte  = m_byte_reg;
    assign m_byte_index = m_idx_reg;
    assign m_is_binary  = m_bin_reg;
    assign m_last       = m_last_reg;

    `SLA_ASSERT(a_line_end_to_emit, aclk, aresetn, (in_acc && line_end) |=> (state_reg == ST_EMIT && rd_addr_reg == '0), "line end did not start readout")
    `SLA_ASSERT(a_last_read_done, aclk, aresetn, (issue && rd_is_last) |=> (state_reg == ST_COLLECT), "readout did not stop after last read")
    `SLA_ASSERT(a_p1_hold, aclk, aresetn, (p1_valid_reg && !out_load) |=> (p1_valid_reg && $stable(p1_idx_reg)), "read stage dropped a byte")
    `SLA_ASSERT(a_binpay_pos, aclk, aresetn, (mode_reg == MODE_BINPAY) |-> (pos_reg >= ADDR_W'(2)), "binary payload position below header")

endmodule
